@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the search core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

@@ rtl/core/bpfm_pkg.sv @@
package bpfm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int CELL_COUNT  = MAX_PATTERN - 1;
  localparam int SEL_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 5;
  localparam int POS_W       = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 2'd3;

  typedef logic [MAX_PATTERN-1:0][7:0] pattern_t;

  // Control shared by every cell of the window.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

@@ rtl/core/bpfm_cell.sv @@
// One stage of the byte window: holds one earlier byte, passes it on to the
// next stage and checks it against the pattern byte that lines up with it.
module bpfm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  bpfm_pkg::cell_ctrl_t         ctrl,
  input  logic [bpfm_pkg::SEL_W-1:0]   cell_index,
  input  logic [bpfm_pkg::LEN_W-1:0]   pattern_length,
  input  bpfm_pkg::pattern_t           pattern,
  input  logic [7:0]                   byte_in,
  output logic [7:0]                   byte_out,
  output logic                         byte_ok
);

  logic [7:0]                 held;
  logic [bpfm_pkg::LEN_W-1:0] index_ext;
  logic [bpfm_pkg::LEN_W-1:0] sel;
  logic                       active;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'd0;
    end else if (ctrl.shift) begin
      held <= ctrl.clear ? 8'd0 : byte_in;
    end
  end

  // Cell i holds the byte i+1 places back, which meets pattern byte len-2-i.
  assign index_ext = {1'b0, cell_index};
  assign sel       = pattern_length - bpfm_pkg::LEN_W'(2) - index_ext;
  assign active    = (index_ext + bpfm_pkg::LEN_W'(1)) < pattern_length;
  assign byte_ok   = !active || (held == pattern[sel[bpfm_pkg::SEL_W-1:0]]);
  assign byte_out  = held;

endmodule

@@ rtl/core/byte_pattern_first_match_search_core.sv @@
// A result is registered on the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle, held only while a result waits on a stalled output.
// The rate is set by the row of window cells, whose comparisons against the pattern bytes are all combinational.
// Reset clears the window, position, match flag and output valid, and loads the
// register defaults (pattern length one, pattern, start position zero); no clearing pass.
`include "assert_macros.svh"

module byte_pattern_first_match_search_core (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes.
  input  logic                             cfg_write,
  input  logic [bpfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpfm_pkg::CFG_W-1:0]       cfg_data,
  // File byte requests.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  // Result requests.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [bpfm_pkg::POS_W-1:0]       match_position
);

  localparam int CELLS = bpfm_pkg::CELL_COUNT;

  // Configuration registers.
  logic [bpfm_pkg::LEN_W-1:0] pattern_length;
  logic [bpfm_pkg::CFG_W-1:0] pattern_low_bytes;
  logic [bpfm_pkg::CFG_W-1:0] pattern_high_bytes;
  logic [bpfm_pkg::POS_W-1:0] start_position;

  // Per-file state.
  logic [bpfm_pkg::POS_W-1:0] byte_position;
  logic                       match_done;

  logic                       accept;
  logic                       out_free;
  bpfm_pkg::pattern_t         pattern;
  bpfm_pkg::cell_ctrl_t       ctrl;
  logic [7:0]                 chain [CELLS+1];
  logic [CELLS-1:0]           cell_ok;

  logic [bpfm_pkg::LEN_W-1:0] len_m1;
  logic [bpfm_pkg::POS_W-1:0] len_m1_ext;
  logic [bpfm_pkg::POS_W-1:0] begin_pos;
  logic                       len_ok;
  logic                       window_ok;
  logic                       newest_ok;
  logic                       hit;
  logic                       emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= bpfm_pkg::LEN_W'(1);
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      start_position     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpfm_pkg::REG_PATTERN_LENGTH: pattern_length     <= cfg_data[bpfm_pkg::LEN_W-1:0];
        bpfm_pkg::REG_PATTERN_LOW:    pattern_low_bytes  <= cfg_data;
        bpfm_pkg::REG_PATTERN_HIGH:   pattern_high_bytes <= cfg_data;
        bpfm_pkg::REG_START_POSITION: start_position     <= cfg_data[bpfm_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte 0 of the pattern sits in the least significant bits of the low word.
  assign pattern = {pattern_high_bytes, pattern_low_bytes};

  // The output register frees up when it is empty or its result is taken this
  // cycle, so a new byte may enter in the same cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !out_free;
  assign accept   = in_valid && !in_stall;

  // The final byte of a file also wipes the window for the next file.
  assign ctrl.shift = accept;
  assign ctrl.clear = last_byte;

  assign chain[0] = data_byte;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    bpfm_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .cell_index     (bpfm_pkg::SEL_W'(i)),
      .pattern_length (pattern_length),
      .pattern        (pattern),
      .byte_in        (chain[i]),
      .byte_out       (chain[i+1]),
      .byte_ok        (cell_ok[i])
    );
  end

  // The newest byte closes the window: it meets the final pattern byte. The
  // window must lie wholly inside the file and begin at or after the start.
  assign len_m1     = pattern_length - bpfm_pkg::LEN_W'(1);
  assign len_m1_ext = {{(bpfm_pkg::POS_W-bpfm_pkg::LEN_W){1'b0}}, len_m1};
  assign len_ok     = (pattern_length != '0) &&
                      (pattern_length <= bpfm_pkg::LEN_W'(bpfm_pkg::MAX_PATTERN));
  assign begin_pos  = byte_position - len_m1_ext;
  assign window_ok  = (byte_position >= len_m1_ext) && (begin_pos >= start_position);
  assign newest_ok  = data_byte == pattern[len_m1[bpfm_pkg::SEL_W-1:0]];

  assign hit  = !match_done && len_ok && window_ok && newest_ok && (&cell_ok);
  // A file that ends without a match reports not found on its final byte.
  assign emit = hit || (last_byte && !match_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      match_done    <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position <= '0;
        match_done    <= 1'b0;
      end else begin
        // The position holds at its top value rather than wrapping.
        if (byte_position != '1) begin
          byte_position <= byte_position + bpfm_pkg::POS_W'(1);
        end
        if (hit) begin
          match_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      found          <= hit;
      match_position <= hit ? begin_pos : '0;
    end
  end

  `ASSERT_CLK(a_hit_sets_done, clk, rst, accept && hit && !last_byte |=> match_done, "match flag not set after a found result")
  `ASSERT_CLK(a_last_restarts, clk, rst, accept && last_byte |=> (byte_position == '0) && !match_done, "final byte did not restart the search")
  `ASSERT_CLK(a_position_saturates, clk, rst, accept && !last_byte && (byte_position == '1) |=> byte_position == '1, "byte position wrapped")
  `ASSERT_NEVER(a_not_found_zero, clk, rst, out_valid && !found && (match_position != '0), "not-found result carries a position")
  `ASSERT_NEVER(a_no_hit_when_done, clk, rst, match_done && hit, "second match reported in one file")

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One file byte as it waits to be offered, and one search outcome as the
  // block should report it.
  typedef struct {
    logic [7:0] value;
    logic       last;
  } file_byte_t;

  typedef struct {
    logic                       hit;
    logic [bpfm_pkg::POS_W-1:0] position;
  } search_outcome_t;

  // Input bytes to offer in the random part before it stops.
  localparam int SEARCH_TARGET = 1150;
  // Cycles to let pass once nothing is outstanding; the result register is the
  // only register that lies between a byte and its result.
  localparam int SETTLE_CYCLES = 4;
  // Longest allowed run of cycles without any accepted request. The slowest
  // honest run sees a long stall, a long gap, the settle time and a burst of
  // register writes in one stretch; this is several times that.
  localparam int WATCHDOG_LIMIT = 2000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [bpfm_pkg::CFG_IDX_W-1:0] cfg_index = bpfm_pkg::REG_PATTERN_LENGTH;
  logic [bpfm_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     data_byte = 8'h00;
  logic                           last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           found;
  logic [bpfm_pkg::POS_W-1:0]     match_position;

  byte_pattern_first_match_search_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .match_position (match_position)
  );

  // The bench's own copy of the registers, kept in step with every write.
  logic [bpfm_pkg::LEN_W-1:0] cfg_len = bpfm_pkg::LEN_W'(1);
  bpfm_pkg::pattern_t         cfg_pattern = '0;
  logic [bpfm_pkg::POS_W-1:0] cfg_start = '0;

  // Search state of the file currently streaming: the bytes that came before
  // the current one (newest in entry zero), the position of the next byte and
  // whether this file has already reported its hit.
  logic [7:0]                 history [bpfm_pkg::CELL_COUNT];
  logic [bpfm_pkg::POS_W-1:0] file_pos;
  logic                       file_matched;

  file_byte_t       file_stream[$];
  search_outcome_t  pending_outcomes[$];
  logic [7:0]       file_body[$];

  int  bytes_queued = 0;
  int  bytes_taken = 0;
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  int  byte_gap = 0;
  int  stall_left = 0;
  int  calm_left = 0;
  bit  byte_accepted = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Pause lengths for both sides: mostly none, often short, now and then long.
  // During a calm stretch neither side idles at all.
  function automatic int draw_pause(input int long_max);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_left > 0 || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  // A new file starts with an empty window at position zero.
  function automatic void restart_file();
    foreach (history[i]) history[i] = 8'h00;
    file_pos = '0;
    file_matched = 1'b0;
  endfunction

  // Predicts the outcome of one accepted byte. The pattern window is the
  // current byte plus the bytes held in the history; a hit reports the
  // position of the first pattern byte, and only windows that begin at or
  // after the start position count. A file that ends without a hit reports
  // "not found" on its last byte; once a file has hit, its remaining bytes
  // are skipped and produce nothing.
  task automatic search_byte(input logic [7:0] b, input logic last);
    logic                       hit;
    logic [bpfm_pkg::POS_W-1:0] first_pos;
    int unsigned                len;
    hit = 1'b0;
    first_pos = '0;
    len = cfg_len;
    // A length of zero or above the window size can never match, and a window
    // cannot be complete before enough bytes have arrived.
    if (!file_matched && len != 0 && len <= bpfm_pkg::MAX_PATTERN &&
        file_pos >= bpfm_pkg::POS_W'(len - 1)) begin
      first_pos = file_pos - bpfm_pkg::POS_W'(len - 1);
      if (first_pos >= cfg_start && cfg_pattern[len - 1] == b) begin
        hit = 1'b1;
        for (int k = 0; k + 1 < len; k++)
          if (history[len - 2 - k] != cfg_pattern[k]) hit = 1'b0;
      end
    end
    for (int k = bpfm_pkg::CELL_COUNT - 1; k > 0; k--) history[k] = history[k - 1];
    history[0] = b;
    // The position counter sticks at its top value rather than wrapping.
    if (file_pos != '1) file_pos++;
    if (hit) begin
      pending_outcomes.push_back('{hit: 1'b1, position: first_pos});
      file_matched = 1'b1;
    end else if (last && !file_matched) begin
      pending_outcomes.push_back('{hit: 1'b0, position: '0});
    end
    if (last) restart_file();
  endtask

  // Byte request driver. A new byte is only put up once the previous one has
  // been taken, so a stalled request keeps its payload untouched.
  always @(negedge clk) begin
    file_byte_t next_byte;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_accepted) begin
      if (byte_gap > 0 || file_stream.size() == 0) begin
        in_valid <= 1'b0;
        if (byte_gap > 0) byte_gap--;
      end else begin
        next_byte = file_stream.pop_front();
        in_valid <= 1'b1;
        data_byte <= next_byte.value;
        last_byte <= next_byte.last;
        byte_gap = draw_pause(30);
      end
    end
  end

  // Result stall driver: runs of stall cycles, independent of whether a
  // result is waiting, so the stall lands on every phase of the search.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = draw_pause(40);
    end
  end

  // Monitor: predicts on every accepted byte request, checks every accepted
  // result request against the oldest outstanding outcome, and keeps the
  // watchdog.
  always @(posedge clk) begin
    search_outcome_t want;
    if (rst) begin
      restart_file();
      byte_accepted = 1'b0;
      idle_cycles = 0;
    end else begin
      byte_accepted = in_valid && !in_stall;
      if (byte_accepted) begin
        search_byte(data_byte, last_byte);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found=%0b match_position=%0d",
                   $time, found, match_position);
          mismatch_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (found !== want.hit) begin
            $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.hit, found);
            mismatch_count++;
          end
          if (match_position !== want.position) begin
            $display("%0t: match_position mismatch, expected %0d, actual %0d",
                     $time, want.position, match_position);
            mismatch_count++;
          end
        end
      end
      // Calm stretches switch all idling off for a while on both sides.
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(40, 200);
      if (byte_accepted || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One register write; the bench's copy changes with it. Writes are only
  // issued while no byte is in flight, so the copy never runs ahead of a
  // byte the block has still to see.
  task automatic write_reg(input logic [bpfm_pkg::CFG_IDX_W-1:0] index,
                           input logic [bpfm_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      bpfm_pkg::REG_PATTERN_LENGTH: cfg_len = value[bpfm_pkg::LEN_W-1:0];
      bpfm_pkg::REG_PATTERN_LOW:    cfg_pattern[7:0] = value;
      bpfm_pkg::REG_PATTERN_HIGH:   cfg_pattern[15:8] = value;
      bpfm_pkg::REG_START_POSITION: cfg_start = value[bpfm_pkg::POS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Moves the bytes gathered in file_body onto the stream, marking the final
  // one unless the file is deliberately left open.
  task automatic add_file(input bit close);
    file_byte_t item;
    foreach (file_body[i]) begin
      item.value = file_body[i];
      item.last = close && (i == file_body.size() - 1);
      file_stream.push_back(item);
      bytes_queued++;
    end
    file_body.delete();
  endtask

  // Waits until every byte is taken and every outcome has arrived, then lets
  // the block settle, since skipped bytes may still be in its pipeline.
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int                         queued_base;
    int                         roll;
    int                         files;
    int                         n;
    int                         plen;
    int                         kind;
    int                         at;
    bit                         first_phase;
    logic [7:0]                 sym_a;
    logic [7:0]                 sym_b;
    logic [bpfm_pkg::LEN_W-1:0] length;
    logic [bpfm_pkg::POS_W-1:0] start;
    logic [bpfm_pkg::CFG_W-1:0] value;
    bpfm_pkg::pattern_t         pat;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults: a single zero byte matched from position zero. The
    // hit comes on the first byte, the rest of the file is skipped and its
    // last byte gives nothing.
    @(posedge clk);
    file_body = {8'h00, 8'h7F, 8'hFF};
    add_file(1'b1);
    wait_idle();

    // A zero-length pattern never matches; the file ends not found.
    write_reg(bpfm_pkg::REG_PATTERN_LENGTH, bpfm_pkg::CFG_W'(0));
    @(posedge clk);
    file_body = {8'h00};
    add_file(1'b1);
    wait_idle();

    // A length beyond the window is treated as never matching, even though
    // the all-zero pattern would otherwise agree with the byte.
    write_reg(bpfm_pkg::REG_PATTERN_LENGTH, bpfm_pkg::CFG_W'(bpfm_pkg::MAX_PATTERN + 1));
    @(posedge clk);
    file_body = {8'h00};
    add_file(1'b1);
    wait_idle();

    // Full-width pattern whose match completes exactly on the final byte.
    write_reg(bpfm_pkg::REG_PATTERN_LOW, 64'h00FF_807F_01FE_55AA);
    write_reg(bpfm_pkg::REG_PATTERN_HIGH, 64'hFF00_7F80_FE01_AA55);
    write_reg(bpfm_pkg::REG_PATTERN_LENGTH, bpfm_pkg::CFG_W'(bpfm_pkg::MAX_PATTERN));
    @(posedge clk);
    for (int i = 0; i < bpfm_pkg::MAX_PATTERN; i++) file_body.push_back(cfg_pattern[i]);
    add_file(1'b1);
    wait_idle();

    // Start position beyond the end of the file: the matching bytes do not
    // count, so the file ends not found.
    write_reg(bpfm_pkg::REG_START_POSITION, bpfm_pkg::CFG_W'(32'hFFFF_FFFF));
    write_reg(bpfm_pkg::REG_PATTERN_LENGTH, bpfm_pkg::CFG_W'(1));
    @(posedge clk);
    file_body = {8'hAA, 8'hAA};
    add_file(1'b1);
    wait_idle();

    // Random phases: a fresh register setting, then a handful of files. Most
    // files carry a planted copy of the pattern, sometimes with one bit
    // broken, over a background of pattern bytes or plain noise.
    queued_base = bytes_queued;
    first_phase = 1'b1;
    while (bytes_queued - queued_base < SEARCH_TARGET) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) length = '0;
      else if (roll == 1)
        length = bpfm_pkg::LEN_W'($urandom_range(bpfm_pkg::MAX_PATTERN + 1, 31));
      else if (roll < 5) length = bpfm_pkg::LEN_W'(bpfm_pkg::MAX_PATTERN);
      else if (roll < 12) length = bpfm_pkg::LEN_W'($urandom_range(1, 4));
      else length = bpfm_pkg::LEN_W'($urandom_range(1, bpfm_pkg::MAX_PATTERN - 1));

      pat = {$urandom, $urandom, $urandom, $urandom};
      // A two-symbol pattern makes near misses and overlapping matches common.
      if ($urandom_range(0, 2) == 0) begin
        sym_a = 8'($urandom);
        sym_b = 8'($urandom);
        for (int i = 0; i < bpfm_pkg::MAX_PATTERN; i++)
          pat[i] = $urandom_range(0, 1) ? sym_a : sym_b;
      end

      roll = $urandom_range(0, 19);
      if (roll < 12) start = '0;
      else if (roll < 17) start = bpfm_pkg::POS_W'($urandom_range(1, 30));
      else if (roll < 19) start = bpfm_pkg::POS_W'($urandom);
      else start = '1;

      // The upper bits of the data word are sometimes left random; only the
      // register's own width is kept.
      if (first_phase || $urandom_range(0, 1) == 1) begin
        value = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) value = '0;
        value[bpfm_pkg::LEN_W-1:0] = length;
        write_reg(bpfm_pkg::REG_PATTERN_LENGTH, value);
      end
      if (first_phase || $urandom_range(0, 1) == 1)
        write_reg(bpfm_pkg::REG_PATTERN_LOW, pat[7:0]);
      if (first_phase || $urandom_range(0, 1) == 1)
        write_reg(bpfm_pkg::REG_PATTERN_HIGH, pat[15:8]);
      if (first_phase || $urandom_range(0, 2) == 0) begin
        value = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) value = '0;
        value[bpfm_pkg::POS_W-1:0] = start;
        write_reg(bpfm_pkg::REG_START_POSITION, value);
      end
      first_phase = 1'b0;

      @(posedge clk);
      plen = (cfg_len == 0 || cfg_len > bpfm_pkg::MAX_PATTERN) ? 4 : int'(cfg_len);
      files = $urandom_range(1, 5);
      for (int f = 0; f < files; f++) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 22);
        kind = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
          file_body.push_back(kind < 4 ? cfg_pattern[$urandom_range(0, plen - 1)] : 8'($urandom));
        if (kind < 8 && n >= plen) begin
          at = $urandom_range(0, n - plen);
          for (int i = 0; i < plen; i++) file_body[at + i] = cfg_pattern[i];
          if ($urandom_range(0, 3) == 0)
            file_body[at + $urandom_range(0, plen - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        // Now and then the phase ends part way through a file, so the next
        // register writes land in the middle of it.
        add_file(!(f == files - 1 && $urandom_range(0, 9) == 0));
      end
      wait_idle();
    end

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
